/* rtl/core/bmis_pkg.sv */
`timescale 1ns / 1ps

package bmis_pkg;

   // Data path and word RAM geometry.
   localparam int unsigned DATA_W    = 16;
   localparam int unsigned RAM_DEPTH = 65536;
   localparam int unsigned RAM_IDX_W = $clog2(RAM_DEPTH);

   typedef logic [DATA_W-1:0]    word_type;
   typedef logic [RAM_IDX_W-1:0] ram_idx_type;

   // Bus source codes. Codes above SRC_RAM drive all ones.
   localparam logic [3:0] SRC_IMM   = 4'd0;
   localparam logic [3:0] SRC_ADDR  = 4'd1;
   localparam logic [3:0] SRC_GEN   = 4'd2;
   localparam logic [3:0] SRC_ROTL  = 4'd3;
   localparam logic [3:0] SRC_ROTR  = 4'd4;
   localparam logic [3:0] SRC_OUT   = 4'd5;
   localparam logic [3:0] SRC_DIR   = 4'd6;
   localparam logic [3:0] SRC_INPUT = 4'd7;
   localparam logic [3:0] SRC_RAM   = 4'd8;

   // Action codes. Codes ten to twelve only take the next field.
   localparam logic [3:0] ACT_BRANCH   = 4'd0;
   localparam logic [3:0] ACT_JUMP     = 4'd1;
   localparam logic [3:0] ACT_CLR_OUT  = 4'd2;
   localparam logic [3:0] ACT_SET_OUT  = 4'd3;
   localparam logic [3:0] ACT_CLR_ADDR = 4'd4;
   localparam logic [3:0] ACT_SET_ADDR = 4'd5;
   localparam logic [3:0] ACT_CLR_DIR  = 4'd6;
   localparam logic [3:0] ACT_SET_DIR  = 4'd7;
   localparam logic [3:0] ACT_CLR_GEN  = 4'd8;
   localparam logic [3:0] ACT_SET_GEN  = 4'd9;
   localparam logic [3:0] ACT_WR_LOW   = 4'd13;
   localparam logic [3:0] ACT_WR_HIGH  = 4'd14;
   localparam logic [3:0] ACT_WR_FULL  = 4'd15;

   localparam word_type ALL_ONES  = 16'hffff;
   localparam word_type LOW_BYTE  = 16'h00ff;
   localparam word_type HIGH_BYTE = 16'hff00;
   localparam word_type PC_KEEP   = 16'hfffe;

   // One decoded instruction.
   typedef struct packed {
      logic [3:0] source_select;
      logic [3:0] action;
      word_type   immediate;
      word_type   next_field;
   } item_type;

   // One step result.
   typedef struct packed {
      word_type next_address;
      word_type bus_value;
      word_type out_port;
      word_type dir_port;
      logic     input_fault;
   } result_type;

   // Write request from the execute unit to the word RAM.
   typedef struct packed {
      logic        en;
      ram_idx_type idx;
      word_type    data;
   } ram_wr_type;

endpackage

/* rtl/core/bmis_ram.sv */
`timescale 1ns / 1ps

module bmis_ram (
   input  logic                 clock,
   input  logic                 reset,
   input  bmis_pkg::ram_wr_type wr_req,
   input  bmis_pkg::ram_idx_type rd_idx,
   output bmis_pkg::word_type   rd_data,
   output logic                 clr_busy
);
   import bmis_pkg::*;

   word_type    mem [RAM_DEPTH];
   word_type    rdata_ff;
   word_type    fwd_data_ff;
   logic        fwd_ff;
   logic        fwd_in;
   logic        clr_busy_ff;
   ram_idx_type clr_idx_ff;
   logic        wr_en;
   ram_idx_type wr_idx;
   word_type    wr_data;

   // The clearing sweep owns the write port until every entry holds zero.
   always_comb begin
      wr_en   = clr_busy_ff | wr_req.en;
      wr_idx  = clr_busy_ff ? clr_idx_ff : wr_req.idx;
      wr_data = clr_busy_ff ? '0 : wr_req.data;
      fwd_in  = wr_en && (wr_idx == rd_idx);
   end

   // Single write port and one registered read port; the read sees the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      rdata_ff    <= mem[rd_idx];
      fwd_data_ff <= wr_data;
   end

   // Clearing sweep and forward flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_idx_ff  <= '0;
         fwd_ff      <= 1'b0;
      end else begin
         fwd_ff <= fwd_in;
         if (clr_busy_ff) begin
            clr_idx_ff <= clr_idx_ff + 1'b1;
            if (clr_idx_ff == ram_idx_type'(RAM_DEPTH - 1)) begin
               clr_busy_ff <= 1'b0;
            end
         end
      end
   end

   // A write to the entry being read in the same cycle wins over the stale array data.
   assign rd_data  = fwd_ff ? fwd_data_ff : rdata_ff;
   assign clr_busy = clr_busy_ff;

endmodule

/* rtl/core/bmis_exec.sv */
`timescale 1ns / 1ps

module bmis_exec (
   input  logic                  clock,
   input  logic                  reset,
   input  bmis_pkg::item_type    item,
   input  logic                  fire,
   input  bmis_pkg::word_type    ram_data,
   output bmis_pkg::result_type  result,
   output bmis_pkg::ram_wr_type  ram_wr,
   output bmis_pkg::ram_idx_type rd_idx
);
   import bmis_pkg::*;

   word_type addr_ff, addr_in;
   word_type gen_ff,  gen_in;
   word_type out_ff,  out_in;
   word_type dir_ff,  dir_in;
   word_type pc_ff,   pc_in;
   word_type bus;
   word_type bus_n;
   logic     fault;
   logic     ram_we;
   word_type ram_wdata;

   // Bus source selection.
   always_comb begin
      unique case (item.source_select) inside
         SRC_IMM:   bus = item.immediate;
         SRC_ADDR:  bus = addr_ff;
         SRC_GEN:   bus = gen_ff;
         SRC_ROTL:  bus = {gen_ff[DATA_W-2:0], gen_ff[DATA_W-1]};
         SRC_ROTR:  bus = {gen_ff[0], gen_ff[DATA_W-1:1]};
         SRC_OUT:   bus = out_ff;
         SRC_DIR:   bus = dir_ff;
         SRC_INPUT: bus = '0;
         SRC_RAM:   bus = ram_data;
         default:   bus = ALL_ONES;
      endcase
      fault = (item.source_select == SRC_INPUT);
      bus_n = ~bus;
   end

   // Action decode: next register values and RAM write request.
   always_comb begin
      addr_in = addr_ff;
      gen_in  = gen_ff;
      out_in  = out_ff;
      dir_in  = dir_ff;
      pc_in   = pc_ff;
      ram_we  = 1'b0;
      if (!fault) begin
         pc_in = item.next_field;
         unique case (item.action) inside
            ACT_BRANCH:   pc_in = (item.next_field & PC_KEEP)
                                  | word_type'(|(bus & item.immediate));
            ACT_JUMP:     pc_in = bus;
            ACT_CLR_OUT:  out_in  = out_ff & bus_n;
            ACT_SET_OUT:  out_in  = out_ff | bus;
            ACT_CLR_ADDR: addr_in = addr_ff & bus_n;
            ACT_SET_ADDR: addr_in = addr_ff | bus;
            ACT_CLR_DIR:  dir_in  = dir_ff & bus_n;
            ACT_SET_DIR:  dir_in  = dir_ff | bus;
            ACT_CLR_GEN:  gen_in  = gen_ff & bus_n;
            ACT_SET_GEN:  gen_in  = gen_ff | bus;
            ACT_WR_LOW, ACT_WR_HIGH, ACT_WR_FULL: ram_we = 1'b1;
            default:      ram_we = 1'b0;
         endcase
      end
   end

   // Byte writes merge with the entry read for this instruction.
   always_comb begin
      case (item.action)
         ACT_WR_LOW:  ram_wdata = (ram_data & HIGH_BYTE) | (bus & LOW_BYTE);
         ACT_WR_HIGH: ram_wdata = (ram_data & LOW_BYTE) | (bus & HIGH_BYTE);
         default:     ram_wdata = bus;
      endcase
   end

   // Architectural registers move only when the instruction retires.
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= '0;
         gen_ff  <= '0;
         out_ff  <= '0;
         dir_ff  <= '0;
         pc_ff   <= '0;
      end else if (fire) begin
         addr_ff <= addr_in;
         gen_ff  <= gen_in;
         out_ff  <= out_in;
         dir_ff  <= dir_in;
         pc_ff   <= pc_in;
      end
   end

   // The RAM always reads at the address register value of the next cycle.
   assign rd_idx = fire ? addr_in[RAM_IDX_W-1:0] : addr_ff[RAM_IDX_W-1:0];

   assign ram_wr.en   = fire & ram_we;
   assign ram_wr.idx  = addr_ff[RAM_IDX_W-1:0];
   assign ram_wr.data = ram_wdata;

   assign result.next_address = pc_in;
   assign result.bus_value    = bus;
   assign result.out_port     = out_in;
   assign result.dir_port     = dir_in;
   assign result.input_fault  = fault;

endmodule

/* rtl/core/bus_machine_instruction_step_core.sv */
`timescale 1ns / 1ps

// Executes one decoded bus machine instruction per beat and returns one result beat per
// instruction. After reset the block runs a clearing pass over the 65536-entry word RAM,
// one entry per cycle, and holds req_stall high until the pass is done. After that it
// takes one instruction per clock: an accepted beat is registered into the execute
// stage and executes there, using the RAM entry at the current address register, which
// the synchronous RAM (one write port, one registered read port) has already read; a write
// by the previous instruction to that entry is forwarded. Results sit in an output register,
// so a new beat is taken while a result waits; the input stalls only in the clearing pass
// or when the execute stage and output register are full and rsp_stall is high.
module bus_machine_instruction_step_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [3:0]          req_source_select,
   input  logic [3:0]          req_action,
   input  bmis_pkg::word_type  req_immediate,
   input  bmis_pkg::word_type  req_next_field,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output bmis_pkg::word_type  rsp_next_address,
   output bmis_pkg::word_type  rsp_bus_value,
   output bmis_pkg::word_type  rsp_out_port,
   output bmis_pkg::word_type  rsp_dir_port,
   output logic                rsp_input_fault
);
   import bmis_pkg::*;

   item_type    ex_item_ff, ex_item_in;
   logic        ex_valid_ff, ex_valid_in;
   result_type  rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        ex_fire;
   logic        req_take;
   logic        clr_busy;
   result_type  ex_result;
   ram_wr_type  ram_wr;
   ram_idx_type rd_idx;
   word_type    ram_data;

   // Word RAM with clearing sweep and write forwarding.
   bmis_ram u_ram (
      .clock    (clock),
      .reset    (reset),
      .wr_req   (ram_wr),
      .rd_idx   (rd_idx),
      .rd_data  (ram_data),
      .clr_busy (clr_busy)
   );

   // Register file and instruction execute.
   bmis_exec u_exec (
      .clock    (clock),
      .reset    (reset),
      .item     (ex_item_ff),
      .fire     (ex_fire),
      .ram_data (ram_data),
      .result   (ex_result),
      .ram_wr   (ram_wr),
      .rd_idx   (rd_idx)
   );

   // Handshake: execute retires when the output register is free or drains this cycle.
   always_comb begin
      ex_fire   = ex_valid_ff && (!rsp_valid_ff || !rsp_stall);
      req_stall = clr_busy || (ex_valid_ff && !ex_fire);
      req_take  = req_valid && !req_stall;

      ex_valid_in = req_take || (ex_valid_ff && !ex_fire);
      ex_item_in  = ex_item_ff;
      if (req_take) begin
         ex_item_in.source_select = req_source_select;
         ex_item_in.action        = req_action;
         ex_item_in.immediate     = req_immediate;
         ex_item_in.next_field    = req_next_field;
      end

      rsp_valid_in = ex_fire || (rsp_valid_ff && rsp_stall);
      rsp_in       = ex_fire ? ex_result : rsp_ff;
   end

   // Execute stage and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         ex_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ex_valid_ff  <= ex_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ex_item_ff <= ex_item_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_next_address = rsp_ff.next_address;
   assign rsp_bus_value    = rsp_ff.bus_value;
   assign rsp_out_port     = rsp_ff.out_port;
   assign rsp_dir_port     = rsp_ff.dir_port;
   assign rsp_input_fault  = rsp_ff.input_fault;

   // No instruction retires while the RAM clearing pass is running.
   a_no_fire_in_clear : assert property (@(posedge clock) disable iff (reset)
      clr_busy |-> !ex_fire)
      else $error("instruction retired during RAM clear");

   // A held instruction stays in the execute stage unchanged.
   a_ex_hold : assert property (@(posedge clock) disable iff (reset)
      (ex_valid_ff && !ex_fire) |=> (ex_valid_ff && $stable(ex_item_ff)))
      else $error("execute stage lost a held instruction");

   // A faulting instruction produces a result with the fault flag and an idle bus.
   a_fault_result : assert property (@(posedge clock) disable iff (reset)
      (ex_fire && ex_item_ff.source_select == SRC_INPUT)
      |=> (rsp_valid && rsp_input_fault && rsp_bus_value == '0))
      else $error("input source fault not reported");

   // A faulting instruction never writes the RAM.
   a_fault_no_write : assert property (@(posedge clock) disable iff (reset)
      (ex_valid_ff && ex_item_ff.source_select == SRC_INPUT) |-> !ram_wr.en)
      else $error("RAM written on input source fault");

endmodule

/* tb/tb_bus_machine_instruction_step_core.sv */
`timescale 1ns / 1ps

module tb_bus_machine_instruction_step_core;
   import bmis_pkg::*;

   // Codes without a name in the package: all-ones sources and do-nothing actions.
   localparam logic [3:0] SRC_ONES_FIRST = 4'd9;
   localparam logic [3:0] ACT_NOP_FIRST  = 4'd10;
   localparam logic [3:0] ACT_NOP_LAST   = 4'd12;

   localparam int ITEM_TARGET    = 1925;
   localparam int PAUSE_SPACING  = 700;
   localparam int HOLD_AT_RESULT = 500;
   localparam int HOLD_CYCLES    = 400;
   localparam int DRAIN_CYCLES   = 16;
   localparam int PACE_PERIOD    = 256;
   // The limit leaves room for the RAM clearing pass after reset, which runs with no beat.
   localparam int WATCHDOG_LIMIT = 4 * RAM_DEPTH;

   typedef enum int {PACE_FULL, PACE_LIGHT, PACE_HEAVY} pace_type;

   typedef struct {
      item_type ins;
      bit       wait_idle;
   } queued_instr_type;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_stall;
   logic [3:0] req_source_select = '0;
   logic [3:0] req_action = '0;
   word_type req_immediate = '0;
   word_type req_next_field = '0;
   logic     rsp_valid;
   logic     rsp_stall = 1'b0;
   word_type rsp_next_address;
   word_type rsp_bus_value;
   word_type rsp_out_port;
   word_type rsp_dir_port;
   logic     rsp_input_fault;

   bus_machine_instruction_step_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_source_select(req_source_select),
      .req_action       (req_action),
      .req_immediate    (req_immediate),
      .req_next_field   (req_next_field),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_next_address (rsp_next_address),
      .rsp_bus_value    (rsp_bus_value),
      .rsp_out_port     (rsp_out_port),
      .rsp_dir_port     (rsp_dir_port),
      .rsp_input_fault  (rsp_input_fault)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Machine state as the block should hold it.
   word_type addr_model = '0;
   word_type gen_model  = '0;
   word_type out_model  = '0;
   word_type dir_model  = '0;
   word_type pc_model   = '0;
   bit [DATA_W-1:0] ram_model [RAM_DEPTH];

   queued_instr_type instr_backlog[$];
   result_type       step_results[$];
   int total_items     = 0;
   int accepted_count  = 0;
   int delivered_count = 0;
   int results_seen    = 0;
   int mismatch_count  = 0;

   // Executes one instruction on the machine state and returns the step result.
   function automatic result_type execute_instruction(item_type ins);
      result_type  res;
      word_type    bus;
      word_type    inv;
      ram_idx_type idx;
      res = '0;
      bus = '0;
      idx = ram_idx_type'(addr_model % RAM_DEPTH);
      if (ins.source_select == SRC_INPUT) begin
         // Unsupported input source: fault, and nothing in the machine moves.
         res.input_fault = 1'b1;
      end else begin
         case (ins.source_select)
            SRC_IMM:  bus = ins.immediate;
            SRC_ADDR: bus = addr_model;
            SRC_GEN:  bus = gen_model;
            SRC_ROTL: bus = {gen_model[DATA_W-2:0], gen_model[DATA_W-1]};
            SRC_ROTR: bus = {gen_model[0], gen_model[DATA_W-1:1]};
            SRC_OUT:  bus = out_model;
            SRC_DIR:  bus = dir_model;
            SRC_RAM:  bus = ram_model[idx];
            default:  bus = ALL_ONES;
         endcase
         inv = ~bus;
         pc_model = ins.next_field;
         case (ins.action)
            ACT_BRANCH:   pc_model = (ins.next_field & PC_KEEP) |
                                     {{(DATA_W-1){1'b0}}, |(bus & ins.immediate)};
            ACT_JUMP:     pc_model = bus;
            ACT_CLR_OUT:  out_model &= inv;
            ACT_SET_OUT:  out_model |= bus;
            ACT_CLR_ADDR: addr_model &= inv;
            ACT_SET_ADDR: addr_model |= bus;
            ACT_CLR_DIR:  dir_model &= inv;
            ACT_SET_DIR:  dir_model |= bus;
            ACT_CLR_GEN:  gen_model &= inv;
            ACT_SET_GEN:  gen_model |= bus;
            ACT_WR_LOW:   ram_model[idx] = (ram_model[idx] & HIGH_BYTE) | (bus & LOW_BYTE);
            ACT_WR_HIGH:  ram_model[idx] = (ram_model[idx] & LOW_BYTE) | (bus & HIGH_BYTE);
            ACT_WR_FULL:  ram_model[idx] = bus;
            default:      ;
         endcase
      end
      res.next_address = pc_model;
      res.bus_value    = bus;
      res.out_port     = out_model;
      res.dir_port     = dir_model;
      return res;
   endfunction

   function automatic item_type make_instr(logic [3:0] src, logic [3:0] act,
                                           word_type imm, word_type nf);
      item_type ins;
      ins.source_select = src;
      ins.action        = act;
      ins.immediate     = imm;
      ins.next_field    = nf;
      return ins;
   endfunction

   function automatic void queue_instr(item_type ins, bit wait_idle);
      queued_instr_type entry;
      entry.ins       = ins;
      entry.wait_idle = wait_idle;
      instr_backlog.push_back(entry);
      total_items++;
   endfunction

   // Idle length for one side: mostly none or short, now and then long.
   function automatic int idle_length(pace_type pace);
      int roll;
      roll = $urandom_range(0, 99);
      if (pace == PACE_FULL)
         return 0;
      if (roll < ((pace == PACE_LIGHT) ? 80 : 50))
         return 0;
      if (roll < 96)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [3:0] write_source();
      logic [3:0] src;
      src = 4'($urandom_range(SRC_IMM, SRC_RAM));
      return (src == SRC_INPUT) ? SRC_IMM : src;
   endfunction

   // Stimulus and end of run.
   initial begin : stimulus_proc
      int       roll;
      int       next_pause;
      bit       pause;
      word_type spot;
      logic [3:0] code;

      // Directed beats: register bit ops, rotations, branch both ways, RAM
      // write then read at the same entry, the input fault, all-ones sources.
      queue_instr(make_instr(SRC_IMM, ACT_SET_OUT, ALL_ONES, 16'h0000), 1'b0);
      queue_instr(make_instr(SRC_IMM, ACT_CLR_OUT, LOW_BYTE, ALL_ONES), 1'b0);
      queue_instr(make_instr(SRC_IMM, ACT_SET_DIR, 16'ha5a5, 16'h1234), 1'b0);
      queue_instr(make_instr(SRC_IMM, ACT_CLR_DIR, 16'h0005, 16'h0000), 1'b0);
      queue_instr(make_instr(SRC_IMM, ACT_CLR_GEN, ALL_ONES, 16'h5555), 1'b0);
      queue_instr(make_instr(SRC_IMM, ACT_SET_GEN, 16'h8001, 16'h4321), 1'b0);
      queue_instr(make_instr(SRC_ROTL, ACT_BRANCH, 16'h0003, ALL_ONES), 1'b0);
      queue_instr(make_instr(SRC_ROTR, ACT_BRANCH, 16'h0001, ALL_ONES), 1'b0);
      queue_instr(make_instr(SRC_GEN, ACT_JUMP, 16'h0000, 16'h0000), 1'b0);
      queue_instr(make_instr(SRC_IMM, ACT_SET_ADDR, 16'h00f0, 16'h1111), 1'b0);
      queue_instr(make_instr(SRC_ADDR, ACT_WR_FULL, 16'h0000, 16'h2222), 1'b0);
      queue_instr(make_instr(SRC_RAM, ACT_SET_OUT, 16'h0000, 16'h3333), 1'b0);
      queue_instr(make_instr(SRC_IMM, ACT_WR_LOW, 16'habcd, 16'h4444), 1'b0);
      queue_instr(make_instr(SRC_IMM, ACT_WR_HIGH, 16'h1234, 16'h5555), 1'b0);
      queue_instr(make_instr(SRC_RAM, ACT_JUMP, ALL_ONES, 16'h6666), 1'b0);
      queue_instr(make_instr(SRC_INPUT, ACT_WR_FULL, ALL_ONES, ALL_ONES), 1'b0);
      queue_instr(make_instr(SRC_OUT, ACT_CLR_ADDR, 16'h0000, 16'h7777), 1'b0);
      queue_instr(make_instr(SRC_DIR, ACT_SET_ADDR, 16'h0000, 16'h8888), 1'b0);
      for (code = SRC_ONES_FIRST; code != 4'd0; code++)
         queue_instr(make_instr(code, 4'(ACT_NOP_FIRST + (code % 3)), 16'h0000, 16'h9999),
                     1'b0);
      queue_instr(make_instr(SRC_IMM, ACT_NOP_LAST, 16'h0000, ALL_ONES), 1'b0);

      // Random beats: RAM sequences around a few addresses, register
      // sequences, and raw noise over the whole field ranges.
      next_pause = total_items;
      while (total_items < ITEM_TARGET) begin
         pause = (total_items >= next_pause);
         if (pause)
            next_pause += PAUSE_SPACING;
         roll = $urandom_range(0, 99);
         if (roll < 40) begin
            spot = ($urandom_range(0, 9) < 8) ? word_type'($urandom_range(0, 7))
                                              : word_type'($urandom);
            queue_instr(make_instr(SRC_IMM, ACT_CLR_ADDR, ALL_ONES, 16'($urandom)), pause);
            queue_instr(make_instr(SRC_IMM, ACT_SET_ADDR, spot, 16'($urandom)), 1'b0);
            repeat ($urandom_range(1, 4)) begin
               if ($urandom_range(0, 1))
                  queue_instr(make_instr(write_source(),
                                         4'($urandom_range(ACT_WR_LOW, ACT_WR_FULL)),
                                         16'($urandom), 16'($urandom)), 1'b0);
               else
                  queue_instr(make_instr(SRC_RAM, 4'($urandom), 16'($urandom),
                                         16'($urandom)), 1'b0);
            end
         end else if (roll < 60) begin
            queue_instr(make_instr(SRC_IMM, 4'($urandom_range(ACT_CLR_OUT, ACT_SET_GEN)),
                                   16'($urandom), 16'($urandom)), pause);
            queue_instr(make_instr(4'($urandom_range(SRC_IMM, SRC_RAM)),
                                   4'($urandom_range(ACT_BRANCH, ACT_JUMP)),
                                   16'($urandom), 16'($urandom)), 1'b0);
         end else begin
            queue_instr(make_instr(4'($urandom), 4'($urandom), 16'($urandom),
                                   16'($urandom)), pause);
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Wait for every beat to go in and every result to come back.
      while (accepted_count < total_items || step_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("[bus_machine_instruction_step_core] OK");
      else
         $display("[bus_machine_instruction_step_core] ERROR");
      $finish;
   end

   // Request driver: one instruction beat at a time from the backlog.
   pace_type drive_pace = PACE_FULL;
   int       drive_gap  = 0;
   int       drive_tick = 0;
   item_type offered_ins;

   always @(posedge clock) begin : drive_proc
      logic             offer;
      queued_instr_type entry;
      if (reset) begin
         req_valid <= 1'b0;
         drive_gap = 0;
      end else begin
         drive_tick++;
         if (drive_tick % PACE_PERIOD == 0)
            drive_pace = pace_type'($urandom_range(0, 2));
         offer = req_valid;
         // A beat taken now is executed on the machine state at once.
         if (req_valid && !req_stall) begin
            step_results.push_back(execute_instruction(offered_ins));
            accepted_count++;
            offer = 1'b0;
            drive_gap = idle_length(drive_pace);
         end
         if (rsp_valid && !rsp_stall)
            delivered_count++;
         // Load the next beat unless a gap or a pause for an idle block is due.
         if (!offer) begin
            if (drive_gap > 0) begin
               drive_gap--;
            end else if (instr_backlog.size() != 0 &&
                         (!instr_backlog[0].wait_idle || accepted_count == delivered_count)) begin
               entry = instr_backlog.pop_front();
               offered_ins = entry.ins;
               offer = 1'b1;
               req_source_select <= entry.ins.source_select;
               req_action        <= entry.ins.action;
               req_immediate     <= entry.ins.immediate;
               req_next_field    <= entry.ins.next_field;
            end
         end
         req_valid <= offer;
      end
   end

   function automatic void check_field(string field_name, word_type want, word_type got);
      if (want !== got) begin
         $display("%0t: %s expected %h got %h", $time, field_name, want, got);
         mismatch_count++;
      end
   endfunction

   // Result monitor: checks each result beat and drives the receiver stall.
   pace_type check_pace = PACE_FULL;
   int       check_tick = 0;
   int       stall_left = 0;
   int       hold_left  = 0;
   bit       hold_done  = 1'b0;

   always @(posedge clock) begin : check_proc
      result_type want;
      int         len;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         check_tick++;
         if (check_tick % PACE_PERIOD == PACE_PERIOD / 2)
            check_pace = pace_type'($urandom_range(0, 2));
         if (rsp_valid && !rsp_stall) begin
            if (step_results.size() == 0) begin
               $display("%0t: result beat with nothing expected, next_address %h",
                        $time, rsp_next_address);
               mismatch_count++;
            end else begin
               want = step_results.pop_front();
               check_field("next_address", want.next_address, rsp_next_address);
               check_field("bus_value", want.bus_value, rsp_bus_value);
               check_field("out_port", want.out_port, rsp_out_port);
               check_field("dir_port", want.dir_port, rsp_dir_port);
               check_field("input_fault", word_type'(want.input_fault),
                           word_type'(rsp_input_fault));
            end
            results_seen++;
         end
         // One long hold-off so the block backs up into its input.
         if (!hold_done && results_seen >= HOLD_AT_RESULT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            len = idle_length(check_pace);
            stall_left = (len > 0) ? len - 1 : 0;
            rsp_stall <= (len > 0);
         end
      end
   end

   // Watchdog: too many cycles in a row without any beat on either side.
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $time, idle_cycles);
         $display("[bus_machine_instruction_step_core] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
